// File: rtl/core/mcms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcms_pkg: shared definitions of the multi-click mode selector
// Holds the mode codes, register indexes, reset values and the structures
// that pass between the configuration file, the decoder core and the
// result buffer.
// ----------------------------------------------------------------------------
package mcms_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int OBUF_DEPTH    = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_0       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_1       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_2       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_3       = 3'd5;

    // Register reset values.
    localparam logic [15:0] CLICK_WINDOW_RST = 16'd750;
    localparam logic [15:0] SETTLE_TICKS_RST = 16'd100;
    localparam logic [7:0]  DUTY_0_RST       = 8'd255;
    localparam logic [7:0]  DUTY_1_RST       = 8'd128;
    localparam logic [7:0]  DUTY_2_RST       = 8'd64;
    localparam logic [7:0]  DUTY_3_RST       = 8'd10;

    // Input operation codes.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_CHANGE = 1'b1;

    // LED mode codes; the fourth code is never reached.
    localparam logic [1:0] MODE_A   = 2'd0;
    localparam logic [1:0] MODE_B   = 2'd1;
    localparam logic [1:0] MODE_RED = 2'd2;

    localparam logic [1:0] CLICK_MAX = 2'd3;

    typedef struct packed {
        logic red;
        logic b;
        logic a;
    } enables_t;

    localparam enables_t ENABLES_RST = '{red: 1'b0, b: 1'b0, a: 1'b1};
    localparam enables_t ENABLES_OFF = '{red: 1'b0, b: 1'b0, a: 1'b0};

    typedef struct packed {
        logic [15:0]     click_window;
        logic [15:0]     settle_ticks;
        logic [3:0][7:0] duty_level;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       a_enabled;
        logic       b_enabled;
        logic       red_enabled;
        logic [7:0] duty_a;
        logic [7:0] duty_b;
        logic       sleeping;
    } result_t;

    // Next mode in the single-click cycle A, B, red.
    function automatic logic [1:0] next_mode(input logic [1:0] mode);
        logic [1:0] nm;
        unique case (mode)
            MODE_A:  nm = MODE_B;
            MODE_B:  nm = MODE_RED;
            default: nm = MODE_A;
        endcase
        return nm;
    endfunction

    // Enable set for a mode; the unused code keeps the present set.
    function automatic enables_t light_mode(input logic [1:0] mode, input enables_t cur);
        enables_t en;
        unique case (mode)
            MODE_A:   en = '{red: 1'b0, b: 1'b0, a: 1'b1};
            MODE_B:   en = '{red: 1'b0, b: 1'b1, a: 1'b0};
            MODE_RED: en = '{red: 1'b1, b: 1'b0, a: 1'b0};
            default:  en = cur;
        endcase
        return en;
    endfunction

endpackage

// File: rtl/core/mcms_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcms_cfg_regs: configuration register file
// Holds the click window, settle delay and the four duty levels, written
// through a plain index and data port.
// ----------------------------------------------------------------------------
module mcms_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mcms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcms_pkg::CFG_DATA_W-1:0] cfg_data,
    output mcms_pkg::cfg_t                  cfg
);

    mcms_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.click_window  <= mcms_pkg::CLICK_WINDOW_RST;
            cfg_reg.settle_ticks  <= mcms_pkg::SETTLE_TICKS_RST;
            cfg_reg.duty_level[0] <= mcms_pkg::DUTY_0_RST;
            cfg_reg.duty_level[1] <= mcms_pkg::DUTY_1_RST;
            cfg_reg.duty_level[2] <= mcms_pkg::DUTY_2_RST;
            cfg_reg.duty_level[3] <= mcms_pkg::DUTY_3_RST;
        end
        else if (cfg_wr_en)
        begin
            // Indexes past the last register are ignored.
            unique case (cfg_index)
                mcms_pkg::REG_CLICK_WINDOW: cfg_reg.click_window  <= cfg_data;
                mcms_pkg::REG_SETTLE_TICKS: cfg_reg.settle_ticks  <= cfg_data;
                mcms_pkg::REG_DUTY_0:       cfg_reg.duty_level[0] <= cfg_data[7:0];
                mcms_pkg::REG_DUTY_1:       cfg_reg.duty_level[1] <= cfg_data[7:0];
                mcms_pkg::REG_DUTY_2:       cfg_reg.duty_level[2] <= cfg_data[7:0];
                mcms_pkg::REG_DUTY_3:       cfg_reg.duty_level[3] <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/mcms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcms_core: click decoder state and single-pass update
// Applies one accepted request to the decoder state and forms the result
// from the updated state in the same cycle.
// ----------------------------------------------------------------------------
module mcms_core #(
    parameter int TIME_BITS = mcms_pkg::TIME_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              op,
    input  logic              vcc_level,
    input  mcms_pkg::cfg_t    cfg,
    output mcms_pkg::result_t res
);

    // Compare width wide enough for the time and for twice the window.
    localparam int CW = ((TIME_BITS > 17) ? TIME_BITS : 17) + 1;

    logic [TIME_BITS-1:0] tick_count_reg, tick_count_next;
    logic [TIME_BITS-1:0] last_click_reg, last_click_next;
    logic [TIME_BITS-1:0] change_mark_reg, change_mark_next;
    logic                 pending_reg, pending_next;
    logic [1:0]           click_count_reg, click_count_next;
    logic [1:0]           mode_reg, mode_next;
    logic [1:0]           idx_a_reg, idx_a_next;
    logic [1:0]           idx_b_reg, idx_b_next;
    logic [1:0]           idx_red_reg, idx_red_next;
    mcms_pkg::enables_t   enables_reg, enables_next;
    logic                 asleep_reg, asleep_next;

    logic [TIME_BITS-1:0] tick_inc;
    logic                 serve_single;
    logic                 serve_double;
    logic                 change_hit;

    // Deadline test without wrap: not met while t is below the start.
    function automatic logic reached(input logic [TIME_BITS-1:0] t,
                                     input logic [TIME_BITS-1:0] start,
                                     input logic [16:0]          delay);
        logic [CW-1:0] diff;
        diff = CW'(t) - CW'(start);
        return (t >= start) && (diff >= CW'(delay));
    endfunction

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        last_click_next  = last_click_reg;
        change_mark_next = change_mark_reg;
        pending_next     = pending_reg;
        click_count_next = click_count_reg;
        mode_next        = mode_reg;
        idx_a_next       = idx_a_reg;
        idx_b_next       = idx_b_reg;
        idx_red_next     = idx_red_reg;
        enables_next     = enables_reg;
        asleep_next      = asleep_reg;

        tick_inc     = (tick_count_reg == '1) ? tick_count_reg
                                              : tick_count_reg + TIME_BITS'(1);
        serve_single = (click_count_reg == 2'd1)
                       && reached(tick_inc, last_click_reg,
                                  {cfg.click_window, 1'b0});
        serve_double = (click_count_reg == 2'd2);
        change_hit   = 1'b0;

        if (op == mcms_pkg::OP_CHANGE)
        begin
            change_mark_next = tick_count_reg;
            pending_next     = 1'b1;
            asleep_next      = 1'b0;
        end
        else if (!asleep_reg)
        begin
            tick_count_next = tick_inc;
            if (serve_single)
            begin
                mode_next        = mcms_pkg::next_mode(mode_reg);
                enables_next     = mcms_pkg::light_mode(mode_next, enables_reg);
                last_click_next  = '0;
                tick_count_next  = '0;
                click_count_next = 2'd0;
            end
            else if (serve_double)
            begin
                unique case (mode_reg)
                    mcms_pkg::MODE_A:   idx_a_next   = idx_a_reg + 2'd1;
                    mcms_pkg::MODE_B:   idx_b_next   = idx_b_reg + 2'd1;
                    mcms_pkg::MODE_RED: idx_red_next = idx_red_reg + 2'd1;
                    default:            ;
                endcase
                last_click_next  = '0;
                tick_count_next  = '0;
                click_count_next = 2'd0;
            end

            change_hit = pending_reg
                         && reached(tick_count_next, change_mark_reg,
                                    {1'b0, cfg.settle_ticks});
            if (change_hit)
            begin
                pending_next     = 1'b0;
                change_mark_next = '0;
                if (vcc_level)
                begin
                    last_click_next = tick_count_next;
                    if (click_count_next != mcms_pkg::CLICK_MAX)
                    begin
                        click_count_next = click_count_next + 2'd1;
                    end
                    enables_next = mcms_pkg::light_mode(mode_next, enables_next);
                end
                else
                begin
                    enables_next = mcms_pkg::ENABLES_OFF;
                    asleep_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            last_click_reg  <= '0;
            change_mark_reg <= '0;
            pending_reg     <= 1'b0;
            click_count_reg <= 2'd0;
            mode_reg        <= mcms_pkg::MODE_A;
            idx_a_reg       <= 2'd0;
            idx_b_reg       <= 2'd0;
            idx_red_reg     <= 2'd0;
            enables_reg     <= mcms_pkg::ENABLES_RST;
            asleep_reg      <= 1'b0;
        end
        else if (accept)
        begin
            tick_count_reg  <= tick_count_next;
            last_click_reg  <= last_click_next;
            change_mark_reg <= change_mark_next;
            pending_reg     <= pending_next;
            click_count_reg <= click_count_next;
            mode_reg        <= mode_next;
            idx_a_reg       <= idx_a_next;
            idx_b_reg       <= idx_b_next;
            idx_red_reg     <= idx_red_next;
            enables_reg     <= enables_next;
            asleep_reg      <= asleep_next;
        end
    end

    // The result reflects the state after this request.
    always_comb
    begin
        res.mode_now    = mode_next;
        res.a_enabled   = enables_next.a;
        res.b_enabled   = enables_next.b;
        res.red_enabled = enables_next.red;
        res.duty_a      = cfg.duty_level[idx_a_next];
        res.duty_b      = cfg.duty_level[idx_b_next];
        res.sleeping    = asleep_next;
    end

`ifndef NO_ASSERTIONS
    a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
        asleep_reg |-> (enables_reg == mcms_pkg::ENABLES_OFF))
        else $error("LED enabled while asleep");
    a_sleep_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        asleep_reg |-> !pending_reg)
        else $error("pin change pending while asleep");
    a_change_wakes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == mcms_pkg::OP_CHANGE) |=> (!asleep_reg && pending_reg))
        else $error("pin change did not wake the decoder");
`endif

endmodule

// File: rtl/core/mcms_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcms_out_buf: two-entry result buffer
// Decouples the result channel from the request channel so that a new
// request is taken while an earlier result is still waiting.
// ----------------------------------------------------------------------------
module mcms_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcms_pkg::result_t din,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mcms_pkg::result_t dout
);

    localparam int CNT_W = $clog2(mcms_pkg::OBUF_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(mcms_pkg::OBUF_DEPTH);

    logic [CNT_W-1:0]  count_reg, count_next;
    mcms_pkg::result_t head_reg, head_next;
    mcms_pkg::result_t tail_reg, tail_next;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign ready     = (count_reg != FULL);
    assign dout      = head_reg;

    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop)
        begin
            if (count_reg == FULL)
            begin
                head_next = tail_reg;
            end
            else if (push)
            begin
                head_next = din;
            end
        end
        else if (push && count_reg == '0)
        begin
            head_next = din;
        end
        if (push && ((count_reg == FULL && pop) || (count_reg != '0 && count_reg != FULL
                                                     && !pop)))
        begin
            tail_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == FULL && !pop))
        else $error("result pushed into a full buffer");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("result buffer count out of range");
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid)
        else $error("pushed result not presented");
`endif

endmodule

// File: rtl/core/multi_click_mode_selector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_click_mode_selector_top: headlamp click decoder
// Decodes supply-interruption clicks into an LED mode, LED enables and
// duty values for two PWM channels.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the input channel (in_valid/in_ready) is a timer tick
//   (op = 0, with the sampled supply level in vcc_level) or a supply pin
//   change (op = 1). Every request yields exactly one result on the output
//   channel (out_valid/out_ready) carrying the mode, the three LED enables,
//   the duty values of LED A and LED B and the sleep flag.
//   The decoder state is updated in the cycle a request is accepted, and
//   its result is registered in the result buffer and presented from the
//   head entry. One request can be accepted every cycle while in_ready is high.
//   Results go into a two-entry buffer. When the receiver stalls, the block
//   still takes requests until both entries hold results, then drops
//   in_ready until a result is taken.
//   Configuration registers are written through cfg_wr_en, cfg_index and
//   cfg_data with no wait state; write them only while the block is idle.
//   Reset (rst_n low) loads the register defaults, wakes the decoder in
//   LED A mode with LED A enabled, clears all timing state and empties the
//   result buffer.
// ----------------------------------------------------------------------------
module multi_click_mode_selector_top #(
    parameter int TIME_BITS = mcms_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic                            vcc_level,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      mode_now,
    output logic                            a_enabled,
    output logic                            b_enabled,
    output logic                            red_enabled,
    output logic [7:0]                      duty_a,
    output logic [7:0]                      duty_b,
    output logic                            sleeping,
    input  logic                            cfg_wr_en,
    input  logic [mcms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcms_pkg::CFG_DATA_W-1:0] cfg_data
);

    mcms_pkg::cfg_t    cfg;
    mcms_pkg::result_t core_res;
    mcms_pkg::result_t buf_res;
    logic              accept;

    // A request is taken whenever the result buffer has room for its result.
    assign accept = in_valid && in_ready;

    mcms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // State update and result formation for the accepted request.
    mcms_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .vcc_level (vcc_level),
        .cfg       (cfg),
        .res       (core_res)
    );

    // The buffer registers each result and absorbs receiver stalls.
    mcms_out_buf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (core_res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dout      (buf_res)
    );

    assign mode_now    = buf_res.mode_now;
    assign a_enabled   = buf_res.a_enabled;
    assign b_enabled   = buf_res.b_enabled;
    assign red_enabled = buf_res.red_enabled;
    assign duty_a      = buf_res.duty_a;
    assign duty_b      = buf_res.duty_b;
    assign sleeping    = buf_res.sleeping;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multi-click mode selector
// Sends tick and pin-change requests through the valid/ready input, tracks
// the click decoder state in a bench-side model and compares every result
// field by field, under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import mcms_pkg::*;

    // The index after the last duty register decodes to no register at all.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_DUTY_3 + 3'd1;
    localparam int LIMIT_NS = 5_000_000;

    // Result of a freshly reset block: LED A lit at duty index 0, awake.
    localparam result_t RESET_VIEW = '{mode_now: MODE_A, a_enabled: 1'b1, b_enabled: 1'b0,
                                       red_enabled: 1'b0, duty_a: DUTY_0_RST,
                                       duty_b: DUTY_0_RST, sleeping: 1'b0};
    // Same state once duty level 0 has been programmed to its low extreme.
    localparam result_t DARK_A_VIEW = '{mode_now: MODE_A, a_enabled: 1'b1, b_enabled: 1'b0,
                                        red_enabled: 1'b0, duty_a: 8'd0, duty_b: 8'd0,
                                        sleeping: 1'b0};

    typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic                  op;
        logic                  vcc;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        result_t               want;
    } script_row_t;

    typedef struct packed {
        logic op;
        logic vcc;
    } lamp_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic                  vcc_level;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            mode_now;
    logic                  a_enabled;
    logic                  b_enabled;
    logic                  red_enabled;
    logic [7:0]            duty_a;
    logic [7:0]            duty_b;
    logic                  sleeping;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    multi_click_mode_selector_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .vcc_level  (vcc_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mode_now   (mode_now),
        .a_enabled  (a_enabled),
        .b_enabled  (b_enabled),
        .red_enabled(red_enabled),
        .duty_a     (duty_a),
        .duty_b     (duty_b),
        .sleeping   (sleeping),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench-side copy of the decoder: registers first, then the click state.
    // ------------------------------------------------------------------------
    logic [15:0] window_ticks;
    logic [15:0] settle_len;
    logic [7:0]  duty_tab [0:3];

    logic [31:0] now_ticks;
    logic [31:0] click_at;
    logic [31:0] change_at;
    logic        change_armed;
    logic [1:0]  clicks;
    logic [1:0]  lamp_mode;
    logic [1:0]  bright [0:2];   // brightness index per mode, red included
    enables_t    leds;
    logic        dozing;

    // Results the block still owes, oldest first.
    result_t     views_due [$];
    lamp_req_t   req_plan [$];
    script_row_t script [$];

    // Typed-in expectation for the request currently offered, if any.
    bit          cur_typed;
    result_t     cur_want;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int requests_seen;
    int results_seen;
    int mode_steps;
    int level_steps;
    int sleeps;

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hung handshake or a result that never shows up ends here.
    initial
    begin
        #(LIMIT_NS);
        $display("%0t: run limit reached, %0d results still outstanding",
                 $time, views_due.size());
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder model.
    // ------------------------------------------------------------------------
    task automatic reset_lamp_model();
        begin
            window_ticks = CLICK_WINDOW_RST;
            settle_len   = SETTLE_TICKS_RST;
            duty_tab[0]  = DUTY_0_RST;
            duty_tab[1]  = DUTY_1_RST;
            duty_tab[2]  = DUTY_2_RST;
            duty_tab[3]  = DUTY_3_RST;
            now_ticks    = '0;
            click_at     = '0;
            change_at    = '0;
            change_armed = 1'b0;
            clicks       = '0;
            lamp_mode    = MODE_A;
            bright[0]    = '0;
            bright[1]    = '0;
            bright[2]    = '0;
            leds         = ENABLES_RST;
            dozing       = 1'b0;
        end
    endtask

    // A deadline is met only once the counter has reached the start time and
    // then moved on by at least the delay; no wrap-around is allowed.
    function automatic bit deadline_met(input logic [63:0] t, input logic [63:0] start,
                                        input logic [63:0] delay);
        return (t >= start) && ((t - start) >= delay);
    endfunction

    // LED set for a mode; the unused mode code leaves the set as it is.
    function automatic enables_t lamp_for(input logic [1:0] m, input enables_t cur);
        enables_t en;
        en = ENABLES_OFF;
        case (m)
            MODE_A:   en.a = 1'b1;
            MODE_B:   en.b = 1'b1;
            MODE_RED: en.red = 1'b1;
            default:  en = cur;
        endcase
        return en;
    endfunction

    task automatic decode_click_request(input logic op_i, input logic vcc_i,
                                        output result_t view);
        begin
            if (op_i == OP_CHANGE) begin
                // A pin change stamps the time and wakes a sleeping lamp, but
                // the LEDs stay dark until the next click is sampled.
                change_at    = now_ticks;
                change_armed = 1'b1;
                dozing       = 1'b0;
            end
            else if (!dozing) begin
                if (now_ticks != '1)
                    now_ticks = now_ticks + 32'd1;

                if (clicks == 2'd1 &&
                    deadline_met(now_ticks, click_at, {window_ticks, 1'b0})) begin
                    case (lamp_mode)
                        MODE_A:  lamp_mode = MODE_B;
                        MODE_B:  lamp_mode = MODE_RED;
                        default: lamp_mode = MODE_A;
                    endcase
                    leds      = lamp_for(lamp_mode, leds);
                    click_at  = '0;
                    now_ticks = '0;
                    clicks    = '0;
                    mode_steps++;
                end
                else if (clicks == 2'd2) begin
                    if (lamp_mode == MODE_A || lamp_mode == MODE_B || lamp_mode == MODE_RED)
                        bright[lamp_mode] = bright[lamp_mode] + 2'd1;
                    click_at  = '0;
                    now_ticks = '0;
                    clicks    = '0;
                    level_steps++;
                end

                if (change_armed && deadline_met(now_ticks, change_at, settle_len)) begin
                    change_armed = 1'b0;
                    change_at    = '0;
                    if (vcc_i) begin
                        click_at = now_ticks;
                        if (clicks != CLICK_MAX)
                            clicks = clicks + 2'd1;
                        leds = lamp_for(lamp_mode, leds);
                    end
                    else begin
                        leds   = ENABLES_OFF;
                        dozing = 1'b1;
                        sleeps++;
                    end
                end
            end

            view.mode_now    = lamp_mode;
            view.a_enabled   = leds.a;
            view.b_enabled   = leds.b;
            view.red_enabled = leds.red;
            view.duty_a      = duty_tab[bright[MODE_A]];
            view.duty_b      = duty_tab[bright[MODE_B]];
            view.sleeping    = dozing;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        begin
            if (want != got) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Outputs are sampled at the rising edge, before the block's own
    // updates of that edge land. A result is checked before the request of
    // the same edge is modeled, so the queue order never depends on process
    // order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t view;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = {mode_now, a_enabled, b_enabled, red_enabled, duty_a, duty_b, sleeping};
                if (views_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result %h arrived with no request outstanding",
                             $time, got);
                end
                else begin
                    view = views_due.pop_front();
                    check_field("mode_now", view.mode_now, got.mode_now);
                    check_field("a_enabled", view.a_enabled, got.a_enabled);
                    check_field("b_enabled", view.b_enabled, got.b_enabled);
                    check_field("red_enabled", view.red_enabled, got.red_enabled);
                    check_field("duty_a", view.duty_a, got.duty_a);
                    check_field("duty_b", view.duty_b, got.duty_b);
                    check_field("sleeping", view.sleeping, got.sleeping);
                    results_seen++;
                end
            end
            if (in_valid && in_ready) begin
                // The model always steps; a typed-in row only replaces what
                // gets compared.
                decode_click_request(op, vcc_level, view);
                views_due.push_back(cur_typed ? cur_want : view);
                requests_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls at random at the rate set for the current phase.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. All tasks are entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic drive_request(input logic op_i, input logic vcc_i);
        begin
            // Random idle cycles before the request; each loop pass moves to
            // the next falling edge, so valid is assigned once per step.
            while ($urandom_range(0, 99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            op        <= op_i;
            vcc_level <= vcc_i;
            do
                @(posedge clk);
            while (in_ready !== 1'b1);
            @(negedge clk);
        end
    endtask

    // Stop offering requests and let every owed result come out. Each
    // request yields a result, so an empty queue means the block is idle.
    task automatic flush_views();
        begin
            in_valid <= 1'b0;
            while (views_due.size() != 0)
                @(negedge clk);
            repeat (2) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            flush_views();
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            case (idx)
                REG_CLICK_WINDOW: window_ticks = data;
                REG_SETTLE_TICKS: settle_len = data;
                REG_DUTY_0:       duty_tab[0] = data[7:0];
                REG_DUTY_1:       duty_tab[1] = data[7:0];
                REG_DUTY_2:       duty_tab[2] = data[7:0];
                REG_DUTY_3:       duty_tab[3] = data[7:0];
                default:          ;
            endcase
            @(negedge clk);
            cfg_wr_en <= 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed script.
    // ------------------------------------------------------------------------
    function automatic script_row_t req_row(input logic op_i, input logic vcc_i,
                                            input bit typed_i = 1'b0,
                                            input result_t want_i = '0);
        script_row_t r;
        r.kind  = ROW_REQ;
        r.op    = op_i;
        r.vcc   = vcc_i;
        r.idx   = '0;
        r.data  = '0;
        r.typed = typed_i;
        r.want  = want_i;
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        script_row_t r;
        r       = req_row(OP_TICK, 1'b0);
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    task automatic build_script();
        begin
            // A pin change at time zero still arms the sampler; with the
            // reset settle delay nothing is sampled on the next tick.
            script.push_back(req_row(OP_CHANGE, 1'b0, 1'b1, RESET_VIEW));
            script.push_back(req_row(OP_TICK,   1'b0, 1'b1, RESET_VIEW));
            // Shortest window and settle delay; duty extremes on levels 0 and 1, with junk in
            // the upper byte of the duty writes that must be dropped.
            script.push_back(reg_row(REG_CLICK_WINDOW, 16'd1));
            script.push_back(reg_row(REG_SETTLE_TICKS, 16'd1));
            script.push_back(reg_row(REG_DUTY_0, 16'hFF00));
            script.push_back(reg_row(REG_DUTY_1, 16'h00FF));
            script.push_back(reg_row(REG_DUTY_2, 16'h81AA));
            script.push_back(reg_row(REG_DUTY_3, 16'h3C55));
            // The change armed at time zero is sampled now: a click.
            script.push_back(req_row(OP_TICK,   1'b1, 1'b1, DARK_A_VIEW));
            // Single click served after twice the window: A to B.
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_TICK,   1'b0));
            // Double click on B, with a repeated change that only re-stamps.
            script.push_back(req_row(OP_CHANGE, 1'b1));
            script.push_back(req_row(OP_CHANGE, 1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_CHANGE, 1'b1));
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_TICK,   1'b0));
            // Single click: B to red.
            script.push_back(req_row(OP_CHANGE, 1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_TICK,   1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
            // Double click on red steps an index that drives nothing.
            script.push_back(req_row(OP_CHANGE, 1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_CHANGE, 1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_TICK,   1'b1));
            // Supply gone at the sample: dark and asleep. Ticks are ignored
            // while asleep, vcc included, until a pin change wakes it.
            script.push_back(req_row(OP_CHANGE, 1'b1));
            script.push_back(req_row(OP_TICK,   1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
            script.push_back(req_row(OP_CHANGE, 1'b0));
            script.push_back(req_row(OP_TICK,   1'b1));
        end
    endtask

    // ------------------------------------------------------------------------
    // Random click sequences.
    // ------------------------------------------------------------------------
    // Huge delays are cut short so the high register extremes stay cheap.
    function automatic int span(input int ticks);
        return (ticks > 400) ? $urandom_range(1, 12) : ticks;
    endfunction

    // vsel: 0 supply absent, 1 supply present, 2 random level.
    task automatic add_ticks(input int n, input int vsel);
        lamp_req_t r;
        begin
            r.op = OP_TICK;
            repeat (n) begin
                r.vcc = (vsel == 2) ? 1'($urandom_range(0, 1)) : 1'(vsel);
                req_plan.push_back(r);
            end
        end
    endtask

    task automatic add_change();
        lamp_req_t r;
        begin
            r.op  = OP_CHANGE;
            r.vcc = 1'($urandom_range(0, 1));
            req_plan.push_back(r);
        end
    endtask

    task automatic plan_random(input int target);
        int        pick;
        int        settle_w;
        lamp_req_t r;
        begin
            settle_w = int'(settle_len);
            while (req_plan.size() < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    // Single click, sometimes with a bouncing pin.
                    add_change();
                    if ($urandom_range(0, 2) == 0)
                        add_change();
                    add_ticks(span(settle_w) + $urandom_range(0, 1), 1);
                    add_ticks(span(2 * int'(window_ticks)) + $urandom_range(0, 3), 2);
                end
                else if (pick < 65) begin
                    // Double click.
                    add_change();
                    add_ticks(span(settle_w) + $urandom_range(0, 1), 1);
                    add_change();
                    add_ticks(span(settle_w) + $urandom_range(0, 1), 1);
                    add_ticks($urandom_range(1, 3), 2);
                end
                else if (pick < 80) begin
                    // Power drop, a few ignored ticks, then a wake-up click.
                    add_change();
                    add_ticks(span(settle_w) + 1, 0);
                    add_ticks($urandom_range(0, 3), 2);
                    add_change();
                    add_ticks(span(settle_w) + $urandom_range(0, 1), 1);
                end
                else begin
                    repeat ($urandom_range(1, 8)) begin
                        r.op  = ($urandom_range(0, 99) < 30) ? OP_CHANGE : OP_TICK;
                        r.vcc = 1'($urandom_range(0, 1));
                        req_plan.push_back(r);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int        window_set [0:5];
        int        settle_set [0:5];
        int        phase_len  [0:5];
        lamp_req_t r;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_TICK;
        vcc_level     = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cur_typed     = 1'b0;
        cur_want      = '0;
        send_idle_pct = 27;
        recv_idle_pct = 70;
        mismatches    = 0;
        requests_seen = 0;
        results_seen  = 0;
        mode_steps    = 0;
        level_steps   = 0;
        sleeps        = 0;
        reset_lamp_model();

        // Reset is held low and released away from the rising edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: register rows wait for an idle block, request rows
        // carry a typed-in result only where it is obvious.
        build_script();
        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                write_reg(script[i].idx, script[i].data);
            end
            else begin
                cur_typed = script[i].typed;
                cur_want  = script[i].want;
                drive_request(script[i].op, script[i].vcc);
            end
        end
        cur_typed = 1'b0;

        // Register settings per phase: both low extremes, small values, both high
        // extremes, random small, a doubled window wider than 8 bits, random small.
        window_set[0] = 1;
        settle_set[0] = 1;
        window_set[1] = 3;
        settle_set[1] = 2;
        window_set[2] = 65535;
        settle_set[2] = 65535;
        window_set[3] = $urandom_range(2, 6);
        settle_set[3] = $urandom_range(1, 5);
        window_set[4] = 150;
        settle_set[4] = 3;
        window_set[5] = $urandom_range(1, 4);
        settle_set[5] = $urandom_range(1, 3);
        phase_len[0]  = 350;
        phase_len[1]  = 350;
        phase_len[2]  = 100;
        phase_len[3]  = 400;
        phase_len[4]  = 400;
        phase_len[5]  = 350;

        for (int p = 0; p < 6; p++) begin
            // Sender-light idling first, then receiver-light, then none.
            case (p / 2)
                0: begin send_idle_pct = 27; recv_idle_pct = 70; end
                1: begin send_idle_pct = 70; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            write_reg(REG_CLICK_WINDOW, CFG_DATA_W'(window_set[p]));
            write_reg(REG_SETTLE_TICKS, CFG_DATA_W'(settle_set[p]));
            if (p == 2) begin
                write_reg(REG_DUTY_0, {8'($urandom_range(0, 255)), 8'h00});
                write_reg(REG_DUTY_1, {8'($urandom_range(0, 255)), 8'hFF});
                write_reg(REG_DUTY_2, {8'($urandom_range(0, 255)), 8'h00});
                write_reg(REG_DUTY_3, {8'($urandom_range(0, 255)), 8'hFF});
            end
            else begin
                write_reg(REG_DUTY_0, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_DUTY_1, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_DUTY_2, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_DUTY_3, CFG_DATA_W'($urandom_range(0, 65535)));
            end
            // A write to an index past the last register must change nothing.
            if (p == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));

            plan_random(phase_len[p]);
            while (req_plan.size() != 0) begin
                r = req_plan.pop_front();
                drive_request(r.op, r.vcc);
            end
        end

        // Everything accepted: collect the owed results, then keep watching the
        // output for any stray result.
        flush_views();
        repeat (4) @(negedge clk);

        $display("Checked %0d results from %0d requests over six register settings",
                 results_seen, requests_seen);
        $display("and three idle patterns: %0d mode steps, %0d brightness steps, %0d sleeps.",
                 mode_steps, level_steps, sleeps);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
